>>> rtl/systematic_resampler_top_macros.svh
`ifndef SYSTEMATIC_RESAMPLER_TOP_MACROS_SVH
`define SYSTEMATIC_RESAMPLER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rs_pkg.sv
`timescale 1ns / 1ps

package rs_pkg;

	// Field widths of the item formats.
	localparam int WEIGHT_W = 17;
	localparam int OFFSET_W = 10;
	localparam int INDEX_W  = 6;

	// One input item: a weight, the end-of-set mark and the start offset.
	typedef struct packed {
		logic [WEIGHT_W-1:0] particle_weight;
		logic                end_of_set;
		logic [OFFSET_W-1:0] start_offset;
	} in_item_t;

	// One result item: the selected particle and the final-draw flag.
	typedef struct packed {
		logic [INDEX_W-1:0] chosen_index;
		logic               last_draw;
	} out_item_t;

endpackage

>>> rtl/rs_stream_if.sv
`timescale 1ns / 1ps

interface rs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/systematic_resampler_top.sv
// Channel  | Direction | Payload                                       | Handshake
// weights  | in        | particle_weight, end_of_set, start_offset     | valid / ready
// draws    | out       | chosen_index, last_draw                       | valid / ready
//
// Weights load one per cycle; ready is low only while a walk is in progress.
// After the end-of-set item the walk primes the weight RAM in states PRIME0 and PRIME1,
// then either advances the cursor or issues a draw at each step, never both; its pace
// is set by the single read port of the weight RAM and the running sum adder.
// A stalled draws channel holds the walk at its next draw; cursor advances go on.
// Reset clears the fill count and the control state; the weight RAM is not cleared.
`timescale 1ns / 1ps
`include "systematic_resampler_top_macros.svh"

module systematic_resampler_top #(
	parameter int PARTICLE_COUNT = 64,
	parameter int FRACTION_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rs_stream_if.sink   weights,
	rs_stream_if.source draws
);
	import rs_pkg::*;

	localparam int IDX_W = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
	localparam int CNT_W = $clog2(PARTICLE_COUNT + 1);
	localparam int CSUM_W = WEIGHT_W + CNT_W;
	localparam int THR_W = ((FRACTION_BITS + 1) > (OFFSET_W + 1)) ?
		(FRACTION_BITS + 1) : (OFFSET_W + 1);
	localparam int SUM_W = ((CSUM_W > THR_W) ? CSUM_W : THR_W) + 1;
	localparam logic [SUM_W-1:0] SPACING =
		SUM_W'((64'd1 << FRACTION_BITS) / PARTICLE_COUNT);
	localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(PARTICLE_COUNT);
	localparam logic [IDX_W-1:0] LAST_M = IDX_W'(PARTICLE_COUNT - 1);

	localparam logic [1:0] ST_LOAD   = 2'd0;
	localparam logic [1:0] ST_PRIME0 = 2'd1;
	localparam logic [1:0] ST_PRIME1 = 2'd2;
	localparam logic [1:0] ST_WALK   = 2'd3;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    cursor_q;
	logic [IDX_W-1:0]    m_q;
	logic [SUM_W-1:0]    csum_q;
	logic [SUM_W-1:0]    thr_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic                accept_in;
	logic                store_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [WEIGHT_W-1:0] rd_data;
	logic [CNT_W-1:0]    cursor_p1;
	logic [CNT_W-1:0]    cursor_p2;
	logic                can_adv;
	logic                slot_free;
	logic                emit;
	logic                emit_last;

	// Input side: weights are taken only outside a walk.
	assign weights.ready = (state_q == ST_LOAD);
	assign accept_in     = weights.valid && weights.ready;
	assign store_en      = accept_in && (count_q < COUNT_FULL);

	// Walk decisions for the current cycle.
	assign cursor_p1 = CNT_W'(cursor_q) + CNT_W'(1);
	assign cursor_p2 = CNT_W'(cursor_q) + CNT_W'(2);
	assign can_adv   = (state_q == ST_WALK) && (thr_q > csum_q) && (cursor_p1 < count_q);
	assign slot_free = !out_valid_q || draws.ready;
	assign emit      = (state_q == ST_WALK) && !can_adv && slot_free;
	assign emit_last = emit && (m_q == LAST_M);

	// During a walk the read address keeps the weight after the cursor in flight.
	always_comb begin
		rd_addr = '0;
		case (state_q)
			ST_PRIME0: rd_addr = '0;
			ST_PRIME1: rd_addr = IDX_W'(1);
			ST_WALK: begin
				if (can_adv) begin
					rd_addr = (cursor_p2 < COUNT_FULL) ? cursor_p2[IDX_W-1:0] : '0;
				end else begin
					rd_addr = (cursor_p1 < COUNT_FULL) ? cursor_p1[IDX_W-1:0] : '0;
				end
			end
			default: rd_addr = '0;
		endcase
	end

	rs_ram #(
		.WIDTH(WEIGHT_W),
		.DEPTH(PARTICLE_COUNT)
	) u_weight_ram (
		.clk  (clk),
		.we   (store_en),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(weights.data.particle_weight),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Control sequencer: load, prime the RAM, then walk the thresholds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= '0;
			cursor_q <= '0;
			m_q      <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (store_en) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (accept_in && weights.data.end_of_set) begin
						state_q  <= ST_PRIME0;
						cursor_q <= '0;
						m_q      <= '0;
					end
				end
				ST_PRIME0: state_q <= ST_PRIME1;
				ST_PRIME1: state_q <= ST_WALK;
				ST_WALK: begin
					if (can_adv) begin
						cursor_q <= cursor_p1[IDX_W-1:0];
					end else if (emit) begin
						m_q <= m_q + IDX_W'(1);
						if (emit_last) begin
							state_q <= ST_LOAD;
							count_q <= '0;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Threshold and running sum datapath.
	always_ff @(posedge clk) begin
		if (accept_in && weights.data.end_of_set) begin
			thr_q <= SUM_W'(weights.data.start_offset);
		end else if (emit) begin
			thr_q <= thr_q + SPACING;
		end
		if (state_q == ST_PRIME1) begin
			csum_q <= SUM_W'(rd_data);
		end else if (can_adv) begin
			csum_q <= csum_q + SUM_W'(rd_data);
		end
	end

	// Output register decouples the walk from the draws channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (draws.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.chosen_index <= INDEX_W'(cursor_q);
			out_q.last_draw    <= emit_last;
		end
	end

	assign draws.valid = out_valid_q;
	assign draws.data  = out_q;

	// The fill count never passes the number of particles.
	`RS_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= COUNT_FULL,
		"fill count beyond particle count")
	// The cursor stays below the number of loaded weights during a walk.
	`RS_ASSERT_NOW(a_cursor_bound, clk, arst_n, state_q == ST_WALK,
		cursor_p1 <= count_q, "cursor past last loaded weight")
	// The final draw ends the walk and empties the store.
	`RS_ASSERT_NEXT(a_last_ends, clk, arst_n, emit_last,
		(state_q == ST_LOAD) && (count_q == '0), "walk did not end after final draw")
	// A walk starts with at least one weight loaded.
	`RS_ASSERT_NEXT(a_walk_nonempty, clk, arst_n,
		accept_in && weights.data.end_of_set, count_q != '0, "walk with empty store")
	// A draw is never issued while an advance is pending.
	`RS_ASSERT_NOW(a_emit_excl, clk, arst_n, emit, !can_adv && slot_free,
		"draw issued during cursor advance")
endmodule

>>> rtl/rs_ram.sv
`timescale 1ns / 1ps

module rs_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> test/draw_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the resampler. It keeps its own copy of the weight
// store, predicts the draws of every walk, and compares each result item with
// the oldest predicted draw.
module draw_checker #(
	parameter int PARTICLE_COUNT = 64,
	parameter int FRACTION_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              w_valid,
	input  logic              w_ready,
	input  rs_pkg::in_item_t  w_data,
	input  logic              d_valid,
	input  logic              d_ready,
	input  rs_pkg::out_item_t d_data,
	output int                error_count,
	output int                outstanding
);
	import rs_pkg::*;

	// Distance between two neighboring thresholds, in 2^-FRACTION_BITS units.
	localparam int unsigned SPACING = (1 << FRACTION_BITS) / PARTICLE_COUNT;

	logic [WEIGHT_W-1:0] stored_weights [PARTICLE_COUNT];
	int unsigned         fill_count;
	out_item_t           expected_draws [$];

	// Prints one line per mismatch and counts it.
	task automatic log_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		error_count++;
	endtask

	// Walks the cumulative weight sum for every evenly spaced threshold and
	// queues the index that each threshold selects.
	function automatic void predict_walk(input logic [OFFSET_W-1:0] offset);
		int unsigned     cursor;
		int unsigned     threshold;
		longint unsigned running_sum;
		out_item_t       draw;

		cursor = 0;
		running_sum = stored_weights[0];
		for (int unsigned m = 0; m < PARTICLE_COUNT; m++) begin
			threshold = offset + m * SPACING;
			// The cursor never moves past the last loaded weight.
			while (threshold > running_sum && cursor + 1 < fill_count) begin
				cursor++;
				running_sum += stored_weights[cursor];
			end
			draw.chosen_index = cursor[INDEX_W-1:0];
			draw.last_draw = (m == PARTICLE_COUNT - 1);
			expected_draws = {expected_draws, draw};
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;

		if (!arst_n) begin
			fill_count = 0;
			expected_draws.delete();
			error_count = 0;
			outstanding <= 0;
		end else begin
			// A weight beyond a full store is dropped; the end mark still starts a walk.
			if (w_valid && w_ready) begin
				if (fill_count < PARTICLE_COUNT) begin
					stored_weights[fill_count] = w_data.particle_weight;
					fill_count++;
				end
				if (w_data.end_of_set) begin
					predict_walk(w_data.start_offset);
					fill_count = 0;
				end
			end

			// Each draw is matched against the oldest prediction.
			if (d_valid && d_ready) begin
				if (expected_draws.size() == 0) begin
					log_mismatch($sformatf("unexpected draw index %0d last %0b",
						d_data.chosen_index, d_data.last_draw));
				end else begin
					want = expected_draws.pop_front();
					if (d_data.chosen_index !== want.chosen_index)
						log_mismatch($sformatf("chosen_index %0d, predicted %0d",
							d_data.chosen_index, want.chosen_index));
					if (d_data.last_draw !== want.last_draw)
						log_mismatch($sformatf("last_draw %0b, predicted %0b",
							d_data.last_draw, want.last_draw));
				end
			end
			outstanding <= expected_draws.size();
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

// Drives sets of particle weights into the resampler and takes its draws,
// with random gaps on both sides; the draw checker predicts and compares.
module tb;
	import rs_pkg::*;

	localparam int N_PARTICLES = 64;
	localparam int UNITY       = 65536;

	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef weight_t weight_q_t [$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   error_count;
	int   outstanding;
	int   items_sent = 0;
	bit   calm = 1'b0;
	bit   hold_request = 1'b0;

	rs_stream_if #(.payload_t(in_item_t))  weights_ch ();
	rs_stream_if #(.payload_t(out_item_t)) draws_ch ();

	systematic_resampler_top #(
		.PARTICLE_COUNT(N_PARTICLES),
		.FRACTION_BITS (16)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.weights(weights_ch),
		.draws  (draws_ch)
	);

	draw_checker #(
		.PARTICLE_COUNT(N_PARTICLES),
		.FRACTION_BITS (16)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.w_valid    (weights_ch.valid),
		.w_ready    (weights_ch.ready),
		.w_data     (weights_ch.data),
		.d_valid    (draws_ch.valid),
		.d_ready    (draws_ch.ready),
		.d_data     (draws_ch.data),
		.error_count(error_count),
		.outstanding(outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// The run cannot take longer than this even with every stall at its longest.
	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

	// Draw side: random stalls, one long hold-off on request, none at the end.
	initial begin
		draws_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_request) begin
				draws_ch.ready <= 1'b0;
				hold_request = 1'b0;
				repeat (400) @(posedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				draws_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				draws_ch.ready <= 1'b1;
				repeat (calm ? 1 : $urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Offers one weight item, sometimes after a gap, and waits until it is taken.
	task automatic offer_weight(input in_item_t item);
		if (!calm && $urandom_range(0, 4) == 0) begin
			weights_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		weights_ch.valid <= 1'b1;
		weights_ch.data <= item;
		do @(posedge clk); while (!weights_ch.ready);
		items_sent++;
	endtask

	// Sends a whole set; the last weight carries the end mark and the offset.
	// With drain set, the sender then waits until every draw has come back.
	task automatic send_set(input weight_q_t set_w, input logic [OFFSET_W-1:0] offset,
			input bit drain);
		in_item_t item;

		foreach (set_w[k]) begin
			item.particle_weight = set_w[k];
			item.end_of_set = (k == set_w.size() - 1);
			item.start_offset = item.end_of_set ? offset : OFFSET_W'($urandom_range(0, 1023));
			offer_weight(item);
		end
		if (drain) begin
			weights_ch.valid <= 1'b0;
			@(posedge clk);
			wait (outstanding == 0);
			@(posedge clk);
		end
	endtask

	initial begin
		weight_q_t        set_w;
		int               set_size;
		int               mode;
		int               remaining;
		int               share;
		int               set_no;
		weight_t          w;
		logic [OFFSET_W-1:0] offset;

		weights_ch.valid <= 1'b0;
		weights_ch.data <= '0;
		wait (arst_n);
		@(posedge clk);

		// Directed sets: a one-weight set, full and empty weights, both offset
		// extremes, weights that fall short of one, and a uniform set.
		send_set('{weight_t'(UNITY)}, 10'd0, 1'b0);
		send_set('{weight_t'(0), weight_t'(0), weight_t'(UNITY)}, 10'd1023, 1'b0);
		send_set('{weight_t'(UNITY), weight_t'(0), weight_t'(0)}, 10'd1023, 1'b0);
		send_set('{weight_t'(100), weight_t'(200), weight_t'(300)}, 10'd512, 1'b0);
		set_w.delete();
		for (int k = 0; k < 8; k++)
			set_w = {set_w, weight_t'(UNITY / 8)};
		send_set(set_w, 10'd1023, 1'b0);
		send_set('{weight_t'(65535), weight_t'(1)}, 10'd341, 1'b1);

		// Random sets: mostly normalized weights, some noise, a few overfull.
		set_no = 0;
		while (items_sent < 360) begin
			if (set_no == 0)
				set_size = N_PARTICLES + 2;
			else if ($urandom_range(0, 9) < 7)
				set_size = $urandom_range(1, 16);
			else if ($urandom_range(0, 4) != 0)
				set_size = $urandom_range(17, N_PARTICLES);
			else
				set_size = $urandom_range(N_PARTICLES, N_PARTICLES + 4);

			mode = $urandom_range(0, 9);
			remaining = UNITY;
			set_w.delete();
			for (int k = 0; k < set_size; k++) begin
				if (mode < 7) begin
					// Split one whole among the weights at random.
					share = 2 * remaining / (set_size - k);
					if (share > remaining)
						share = remaining;
					w = (k == set_size - 1) ? weight_t'(remaining)
						: weight_t'($urandom_range(0, share));
					remaining -= w;
				end else if (mode < 9) begin
					w = weight_t'($urandom_range(0, UNITY));
				end else begin
					case ($urandom_range(0, 2))
						0: w = '0;
						1: w = weight_t'(UNITY);
						default: w = weight_t'($urandom_range(0, 2000));
					endcase
				end
				set_w = {set_w, w};
			end

			case ($urandom_range(0, 5))
				0: offset = '0;
				1: offset = '1;
				default: offset = OFFSET_W'($urandom_range(0, 1023));
			endcase

			if (set_no == 3)
				hold_request = 1'b1;
			if (items_sent >= 300)
				calm = 1'b1;
			send_set(set_w, offset, set_no % 7 == 5);
			set_no++;
		end
		weights_ch.valid <= 1'b0;

		// Let the last walk finish and catch any stray draw after it.
		@(posedge clk);
		wait (outstanding == 0);
		repeat (2 * N_PARTICLES + 8) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/rs_pkg.sv
rtl/rs_stream_if.sv
rtl/rs_ram.sv
rtl/systematic_resampler_top.sv
test/draw_checker.sv
test/tb.sv
